>>> design/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmd_pkg;

    // Input request kinds carried on s_tuser
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_MAX_PACKET = 1'b0;
    localparam logic REG_CLIENT_ID  = 1'b1;

    localparam logic [31:0] MAX_PACKET_RESET = 32'd8192;
    localparam logic [31:0] HEADER_BYTES     = 32'd6;
    localparam logic [2:0]  LAST_LENGTH_IDX  = 3'd3;
    localparam logic [2:0]  LAST_HEADER_IDX  = 3'd5;

    // Result kinds passed from front to back
    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_EMPTY,
        KIND_BAD,
        KIND_ABORT
    } lpmd_kind_t;

    // One queued result, before the client tag is attached
    typedef struct packed {
        lpmd_kind_t  kind;
        logic [15:0] msg_type;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } lpmd_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } lpmd_qstat_t;

endpackage

`default_nettype wire

>>> design/lpmd_front.sv
// ----------------------------------------------------------------------------
// lpmd_front
// Header parser: accepts bytes and restarts, tracks framing state and
// pushes one classified result per request that produces one.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_front
    import lpmd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data
    input  wire logic        s_tuser,   // [0] op
    input  wire logic [31:0] max_packet_size,
    input  wire lpmd_qstat_t qstat,
    output logic             push,
    output lpmd_entry_t      push_entry
);

    logic [2:0]  hdr_idx_reg,    hdr_idx_next;
    logic [31:0] len_reg,        len_next;
    logic [15:0] type_reg,       type_next;
    logic [31:0] remain_reg,     remain_next;
    logic [31:0] plen_reg,       plen_next;
    logic        in_payload_reg, in_payload_next;
    logic        halted_reg,     halted_next;

    logic        accept;
    logic [31:0] full_len;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign full_len = {s_tdata, len_reg[23:0]};

    // Advance framing state for each accepted request
    always_comb
    begin
        hdr_idx_next    = hdr_idx_reg;
        len_next        = len_reg;
        type_next       = type_reg;
        remain_next     = remain_reg;
        plen_next       = plen_reg;
        in_payload_next = in_payload_reg;
        halted_next     = halted_reg;
        push            = 1'b0;
        push_entry      = '{kind: KIND_ABORT, msg_type: 16'd0, payload_length: 32'd0,
                            data_byte: 8'd0, last: 1'b0};
        if (accept)
        begin
            if (s_tuser == OP_RESTART)
            begin
                // Clear framer; report a cut message
                push            = !halted_reg && (in_payload_reg || hdr_idx_reg != 3'd0);
                hdr_idx_next    = 3'd0;
                len_next        = 32'd0;
                type_next       = 16'd0;
                remain_next     = 32'd0;
                in_payload_next = 1'b0;
                halted_next     = 1'b0;
            end
            else if (halted_reg)
            begin
                // Drop bytes until restart
            end
            else if (in_payload_reg)
            begin
                push                      = 1'b1;
                push_entry.kind           = KIND_PAYLOAD;
                push_entry.msg_type       = type_reg;
                push_entry.payload_length = plen_reg;
                push_entry.data_byte      = s_tdata;
                push_entry.last           = (remain_reg <= 32'd1);
                if (remain_reg <= 32'd1)
                begin
                    hdr_idx_next    = 3'd0;
                    len_next        = 32'd0;
                    type_next       = 16'd0;
                    remain_next     = 32'd0;
                    in_payload_next = 1'b0;
                end
                else
                begin
                    remain_next = remain_reg - 32'd1;
                end
            end
            else if (hdr_idx_reg <= LAST_LENGTH_IDX)
            begin
                // Collect the little-endian length
                hdr_idx_next = hdr_idx_reg + 3'd1;
                case (hdr_idx_reg[1:0])
                    2'd0:    len_next[7:0]   = s_tdata;
                    2'd1:    len_next[15:8]  = s_tdata;
                    2'd2:    len_next[23:16] = s_tdata;
                    default: len_next[31:24] = s_tdata;
                endcase
                if (hdr_idx_reg == LAST_LENGTH_IDX &&
                    (full_len < HEADER_BYTES || full_len > max_packet_size))
                begin
                    push            = 1'b1;
                    push_entry.kind = KIND_BAD;
                    hdr_idx_next    = 3'd0;
                    len_next        = 32'd0;
                    type_next       = 16'd0;
                    remain_next     = 32'd0;
                    halted_next     = 1'b1;
                end
            end
            else if (hdr_idx_reg != LAST_HEADER_IDX)
            begin
                // Low type byte
                hdr_idx_next   = hdr_idx_reg + 3'd1;
                type_next[7:0] = s_tdata;
            end
            else if (len_reg == HEADER_BYTES)
            begin
                // Header done, message without payload
                push                = 1'b1;
                push_entry.kind     = KIND_EMPTY;
                push_entry.msg_type = {s_tdata, type_reg[7:0]};
                push_entry.last     = 1'b1;
                hdr_idx_next        = 3'd0;
                len_next            = 32'd0;
                type_next           = 16'd0;
                remain_next         = 32'd0;
            end
            else
            begin
                // Header done, enter payload
                hdr_idx_next    = 3'd0;
                type_next       = {s_tdata, type_reg[7:0]};
                remain_next     = len_reg - HEADER_BYTES;
                plen_next       = len_reg - HEADER_BYTES;
                in_payload_next = 1'b1;
            end
        end
    end

    // Hold framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg    <= 3'd0;
            len_reg        <= 32'd0;
            type_reg       <= 16'd0;
            remain_reg     <= 32'd0;
            in_payload_reg <= 1'b0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            hdr_idx_reg    <= hdr_idx_next;
            len_reg        <= len_next;
            type_reg       <= type_next;
            remain_reg     <= remain_next;
            in_payload_reg <= in_payload_next;
            halted_reg     <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plen_reg <= plen_next;
    end

    a_halted_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (!in_payload_reg && hdr_idx_reg == 3'd0))
        else $error("halted while framing");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (remain_reg != 32'd0 && hdr_idx_reg == 3'd0))
        else $error("payload state without remaining bytes");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("push into full queue");

    a_halt_after_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_entry.kind == KIND_BAD) |=> halted_reg)
        else $error("bad length did not halt");

endmodule

`default_nettype wire

>>> design/lpmd_queue.sv
// ----------------------------------------------------------------------------
// lpmd_queue
// Two-entry result queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_queue
    import lpmd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire lpmd_entry_t push_entry,
    input  wire logic        pop,
    output lpmd_entry_t      head,
    output lpmd_qstat_t      qstat
);

    lpmd_entry_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !pop)
        else $error("pop from empty queue");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");

endmodule

`default_nettype wire

>>> design/lpmd_back.sv
// ----------------------------------------------------------------------------
// lpmd_back
// Output stage: pops queued results, tags them with the client id and
// holds them on the master stream until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_back
    import lpmd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] client_id,
    input  wire lpmd_entry_t head,
    input  wire lpmd_qstat_t qstat,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [31:0] client_tag, [47:32] msg_type,
                                        // [79:48] payload_length, [87:80] data_byte
    output logic [2:0]       m_tuser,   // [0] has_byte, [1] bad_length, [2] aborted
    output logic             m_tlast    // last
);

    logic        vld_reg,  vld_next;
    logic [87:0] data_reg, data_next;
    logic [2:0]  user_reg, user_next;
    logic        last_reg, last_next;

    assign pop      = !qstat.empty && (!vld_reg || m_tready);
    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // Load the next result when the output register frees up
    always_comb
    begin
        vld_next  = vld_reg;
        data_next = data_reg;
        user_next = user_reg;
        last_next = last_reg;
        if (vld_reg && m_tready)
        begin
            vld_next = 1'b0;
        end
        if (pop)
        begin
            vld_next  = 1'b1;
            data_next = {head.data_byte, head.payload_length, head.msg_type, client_id};
            last_next = head.last;
            case (head.kind)
                KIND_PAYLOAD: user_next = 3'b001;
                KIND_EMPTY:   user_next = 3'b000;
                KIND_BAD:     user_next = 3'b010;
                KIND_ABORT:   user_next = 3'b100;
                default:      user_next = 3'b000;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tuser))
        else $error("more than one result flag set");

    a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1] || m_tuser[2])) |-> (m_tdata[87:32] == 56'd0 && !m_tlast))
        else $error("event result carries message fields");

    a_load_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.kind == KIND_PAYLOAD) |=> (m_tuser[0] && m_tdata[87:80] == $past(head.data_byte)))
        else $error("payload byte not loaded");

endmodule

`default_nettype wire

>>> design/length_prefixed_message_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream into length-prefixed messages and delivers payload
// bytes tagged with client id, type, payload length and last mark.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                    Content
//  s_*       in         s_tvalid / s_tready          tdata byte, tuser op
//  m_*       out        m_tvalid / m_tready          tag, type, length, byte, flags
//  APB       in         psel & penable & pwrite      max_packet_size, client_id
//
//  One input request per cycle while s_tready is high; the parser decides
//  combinationally, and each result is registered in the queue and then in the
//  output register before it is on m_*. The two-entry queue plus the output
//  register let input continue while m_tready is low; s_tready drops only once
//  the queue holds two results. Reset clears the framing state apart from the
//  parser's payload length copy; max_packet_size goes to 8192 and client_id to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_deframer
    import lpmd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [31:0] client_tag, [47:32] msg_type,
                                        // [79:48] payload_length, [87:80] data_byte
    output logic [2:0]       m_tuser,   // [0] has_byte, [1] bad_length, [2] aborted
    output logic             m_tlast,   // last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] max_pkt_reg, max_pkt_next;
    logic [31:0] client_reg,  client_next;
    logic        cfg_wr;

    logic        push;
    logic        pop;
    lpmd_entry_t push_entry;
    lpmd_entry_t head;
    lpmd_qstat_t qstat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_comb
    begin
        max_pkt_next = max_pkt_reg;
        client_next  = client_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAX_PACKET: max_pkt_next = pwdata;
                REG_CLIENT_ID:  client_next  = pwdata;
                default:        max_pkt_next = max_pkt_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[2])
            REG_MAX_PACKET: prdata = max_pkt_reg;
            REG_CLIENT_ID:  prdata = client_reg;
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pkt_reg <= MAX_PACKET_RESET;
            client_reg  <= 32'd0;
        end
        else
        begin
            max_pkt_reg <= max_pkt_next;
            client_reg  <= client_next;
        end
    end

    lpmd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .max_packet_size (max_pkt_reg),
        .qstat           (qstat),
        .push            (push),
        .push_entry      (push_entry)
    );

    lpmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    lpmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .client_id (client_reg),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
